>>> rtl/scoped_symbol_table_core_assert.svh
// Assertion macros shared by the scoped symbol table RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef SCOPED_SYMBOL_TABLE_CORE_ASSERT_SVH
`define SCOPED_SYMBOL_TABLE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SST_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("sst: invariant violated");
`define SST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sst: sequence check failed");
`else
`define SST_ASSERT_ALWAYS(label, cond)
`define SST_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/sst_pkg.sv
`default_nettype none
package sst_pkg;

  localparam int MAX_SCOPES     = 16;
  localparam int VARS_PER_SCOPE = 64;
  localparam int TOTAL_ENTRIES  = 256;
  localparam int KEY_BITS       = 64;
  localparam int BASE_BIAS      = 100;

  // Fixed field widths of the ports.
  localparam int OP_W     = 2;
  localparam int NAME_W   = 64;
  localparam int STATUS_W = 3;
  localparam int OFFSET_W = 6;
  localparam int BASE_W   = 9;

  // Derived widths.
  localparam int ENT_W   = $clog2(TOTAL_ENTRIES + 1);
  localparam int IDX_W   = $clog2(TOTAL_ENTRIES);
  localparam int DEPTH_W = $clog2(MAX_SCOPES + 1);
  localparam int SCP_W   = $clog2(MAX_SCOPES);

  localparam logic [OP_W-1:0] OP_ENTER   = 2'd0;
  localparam logic [OP_W-1:0] OP_EXIT    = 2'd1;
  localparam logic [OP_W-1:0] OP_DECLARE = 2'd2;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SCOPE_FULL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_STACK_FULL = 3'd4;

  typedef struct packed {
    logic load;
    logic enter;
    logic exit_fin;
    logic scan;
    logic decl_fin;
    logic look_miss;
    logic off_init;
    logic off_cmp;
  } sst_cmd_t;

  typedef struct packed {
    logic hit;
    logic miss;
    logic is_decl;
    logic off_hit;
  } sst_stat_t;

endpackage
`default_nettype wire

>>> rtl/sst_ram.sv
`default_nettype none
module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/sst_ctrl.sv
`default_nettype none
`include "scoped_symbol_table_core_assert.svh"
module sst_ctrl
  import sst_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [OP_W-1:0] in_op,
  input  sst_stat_t       st,
  output sst_cmd_t        cmd,
  output logic            busy
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_ENTER   = 3'd1;
  localparam logic [2:0] S_EXIT    = 3'd2;
  localparam logic [2:0] S_EXIT_LD = 3'd3;
  localparam logic [2:0] S_SCAN    = 3'd4;
  localparam logic [2:0] S_OFF_RD  = 3'd5;
  localparam logic [2:0] S_OFF_CMP = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (in_op) inside
            OP_ENTER:              state_nxt = S_ENTER;
            OP_EXIT:               state_nxt = S_EXIT;
            OP_DECLARE, OP_LOOKUP: state_nxt = S_SCAN;
            default:               state_nxt = S_IDLE;
          endcase
        end
      end
      S_ENTER: begin
        cmd.enter = 1'b1;
        state_nxt = S_IDLE;
      end
      S_EXIT: begin
        state_nxt = S_EXIT_LD;
      end
      S_EXIT_LD: begin
        cmd.exit_fin = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.hit || st.miss) begin
          if (st.is_decl) begin
            cmd.decl_fin = 1'b1;
            state_nxt    = S_IDLE;
          end else if (st.hit) begin
            cmd.off_init = 1'b1;
            state_nxt    = S_OFF_RD;
          end else begin
            cmd.look_miss = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end
      S_OFF_RD: begin
        state_nxt = S_OFF_CMP;
      end
      S_OFF_CMP: begin
        cmd.off_cmp = 1'b1;
        state_nxt   = st.off_hit ? S_IDLE : S_OFF_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // A finished scan must never keep the machine in the scan loop.
  `SST_ASSERT_NEXT(a_scan_ends, state_r == S_SCAN && (st.hit || st.miss), state_r != S_SCAN)

endmodule
`default_nettype wire

>>> rtl/sst_dp.sv
`default_nettype none
`include "scoped_symbol_table_core_assert.svh"
module sst_dp
  import sst_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [OP_W-1:0]     in_op,
  input  logic [NAME_W-1:0]   in_name_key,
  input  sst_cmd_t            cmd,
  output sst_stat_t           st,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [OFFSET_W-1:0] out_offset,
  output logic [BASE_W-1:0]   out_scope_base
);

  // Control state.
  logic [ENT_W-1:0]   live_r, live_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [ENT_W-1:0]   cur_start_r, cur_start_nxt;
  logic [ENT_W-1:0]   rem_r, rem_nxt;
  logic               pend_r, pend_nxt;
  logic               valid_r, valid_nxt;

  // Operands and results.
  logic [KEY_BITS-1:0] key_r;
  logic                is_decl_r;
  logic [IDX_W-1:0]    pidx_r;
  logic [IDX_W-1:0]    hit_idx_r;
  logic [SCP_W-1:0]    s_r, s_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [OFFSET_W-1:0] offset_r, offset_nxt;
  logic [BASE_W-1:0]   base_r, base_nxt;

  // Memories.
  logic                key_we;
  logic [KEY_BITS-1:0] key_rdata;
  logic                scope_we;
  logic [ENT_W-1:0]    scope_rdata;

  logic [ENT_W-1:0] count;
  logic [ENT_W-1:0] start_val;
  logic             match;

  sst_ram #(.WIDTH(KEY_BITS), .DEPTH(TOTAL_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (live_r[IDX_W-1:0]),
    .wdata (key_r),
    .raddr (IDX_W'(rem_r - ENT_W'(1))),
    .rdata (key_rdata)
  );

  sst_ram #(.WIDTH(ENT_W), .DEPTH(MAX_SCOPES)) u_scope_ram (
    .clk   (clk),
    .we    (scope_we),
    .waddr (depth_r[SCP_W-1:0]),
    .wdata (live_r),
    .raddr (s_r),
    .rdata (scope_rdata)
  );

  assign count     = live_r - cur_start_r;
  assign match     = pend_r && (key_rdata == key_r);
  // The global scope always starts at entry zero and its slot is never written.
  assign start_val = (s_r == '0) ? '0 : scope_rdata;

  assign st.hit     = match;
  assign st.miss    = (rem_r == '0) && !pend_r;
  assign st.is_decl = is_decl_r;
  assign st.off_hit = (start_val <= ENT_W'(hit_idx_r));

  assign scope_we = cmd.enter && (depth_r < DEPTH_W'(MAX_SCOPES));
  assign key_we   = cmd.decl_fin && !match
                    && (32'(count) < 32'(VARS_PER_SCOPE))
                    && (live_r < ENT_W'(TOTAL_ENTRIES));

  always_comb begin
    live_nxt      = live_r;
    depth_nxt     = depth_r;
    cur_start_nxt = cur_start_r;
    rem_nxt       = rem_r;
    pend_nxt      = pend_r;
    s_nxt         = s_r;
    valid_nxt     = 1'b0;
    status_nxt    = status_r;
    offset_nxt    = offset_r;
    base_nxt      = base_r;

    if (cmd.load) begin
      rem_nxt  = live_r;
      pend_nxt = 1'b0;
      // Prepare the read of the enclosing scope's start for an exit.
      s_nxt    = SCP_W'(depth_r - DEPTH_W'(2));
    end

    if (cmd.scan) begin
      if (rem_r != '0) begin
        rem_nxt  = rem_r - ENT_W'(1);
        pend_nxt = 1'b1;
      end else begin
        pend_nxt = 1'b0;
      end
    end

    if (cmd.enter) begin
      valid_nxt  = 1'b1;
      offset_nxt = '0;
      if (scope_we) begin
        depth_nxt     = depth_r + DEPTH_W'(1);
        cur_start_nxt = live_r;
        status_nxt    = ST_OK;
        base_nxt      = BASE_W'(32'(live_r) + BASE_BIAS);
      end else begin
        status_nxt = ST_STACK_FULL;
        base_nxt   = '0;
      end
    end

    if (cmd.exit_fin) begin
      valid_nxt  = 1'b1;
      status_nxt = ST_OK;
      offset_nxt = '0;
      base_nxt   = '0;
      if (depth_r > DEPTH_W'(1)) begin
        depth_nxt     = depth_r - DEPTH_W'(1);
        live_nxt      = cur_start_r;
        cur_start_nxt = (depth_r == DEPTH_W'(2)) ? '0 : scope_rdata;
      end
    end

    if (cmd.decl_fin) begin
      valid_nxt  = 1'b1;
      offset_nxt = '0;
      base_nxt   = '0;
      if (match) begin
        status_nxt = ST_DUPLICATE;
      end else if (32'(count) >= 32'(VARS_PER_SCOPE)) begin
        status_nxt = ST_SCOPE_FULL;
      end else if (live_r >= ENT_W'(TOTAL_ENTRIES)) begin
        status_nxt = ST_STACK_FULL;
      end else begin
        status_nxt = ST_OK;
        offset_nxt = OFFSET_W'(count);
        live_nxt   = live_r + ENT_W'(1);
      end
    end

    if (cmd.look_miss) begin
      valid_nxt  = 1'b1;
      status_nxt = ST_NOT_FOUND;
      offset_nxt = '0;
      base_nxt   = '0;
    end

    if (cmd.off_init) begin
      s_nxt = SCP_W'(depth_r - DEPTH_W'(1));
    end

    if (cmd.off_cmp) begin
      if (st.off_hit) begin
        valid_nxt  = 1'b1;
        status_nxt = ST_OK;
        offset_nxt = OFFSET_W'(ENT_W'(hit_idx_r) - start_val);
        base_nxt   = '0;
      end else begin
        s_nxt = s_r - SCP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r      <= '0;
      depth_r     <= DEPTH_W'(1);
      cur_start_r <= '0;
      rem_r       <= '0;
      pend_r      <= 1'b0;
      valid_r     <= 1'b0;
    end else begin
      live_r      <= live_nxt;
      depth_r     <= depth_nxt;
      cur_start_r <= cur_start_nxt;
      rem_r       <= rem_nxt;
      pend_r      <= pend_nxt;
      valid_r     <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r     <= in_name_key[KEY_BITS-1:0];
      is_decl_r <= (in_op == OP_DECLARE);
    end
    if (cmd.scan) begin
      pidx_r <= IDX_W'(rem_r - ENT_W'(1));
    end
    if (cmd.off_init) begin
      hit_idx_r <= pidx_r;
    end
    s_r      <= s_nxt;
    status_r <= status_nxt;
    offset_r <= offset_nxt;
    base_r   <= base_nxt;
  end

  assign out_valid      = valid_r;
  assign out_status     = status_r;
  assign out_offset     = offset_r;
  assign out_scope_base = base_r;

  `SST_ASSERT_ALWAYS(a_live_bound, live_r <= ENT_W'(TOTAL_ENTRIES))
  `SST_ASSERT_ALWAYS(a_scope_order, cur_start_r <= live_r && depth_r != '0)
  `SST_ASSERT_NEXT(a_single_strobe, valid_r, !valid_r)

endmodule
`default_nettype wire

>>> rtl/scoped_symbol_table_core.sv
// Channel   Transfer when          Ports
// -------   --------------------   -----------------------------------------------
// input     start && !busy         in_op, in_name_key
// result    out_valid (one cycle)  out_status, out_offset, out_scope_base
//
// Enter passes through S_ENTER and exit through S_EXIT and S_EXIT_LD; the result
// strobe follows the last busy state. Declare and lookup scan the key memory from
// the newest entry down, one read per cycle, and a lookup hit then walks outward,
// scope by scope, through the scope start memory.
// Reset is synchronous and leaves only the global scope open, with no entries.
// A new item may be started in the cycle that its predecessor's result is shown;
// the receiver cannot stall, so every result appears for exactly one cycle.
`default_nettype none
module scoped_symbol_table_core
  import sst_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     in_op,
  input  logic [NAME_W-1:0]   in_name_key,
  output logic                out_valid,
  output logic [STATUS_W-1:0] out_status,
  output logic [OFFSET_W-1:0] out_offset,
  output logic [BASE_W-1:0]   out_scope_base
);

  sst_cmd_t  cmd;
  sst_stat_t st;

  sst_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  sst_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_op          (in_op),
    .in_name_key    (in_name_key),
    .cmd            (cmd),
    .st             (st),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_offset     (out_offset),
    .out_scope_base (out_scope_base)
  );

endmodule
`default_nettype wire

>>> tb/sv/sst_checker.sv
`timescale 1ns / 100ps
module sst_checker
  import sst_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic [OP_W-1:0]     in_op,
  input  logic [NAME_W-1:0]   in_name_key,
  input  logic                out_valid,
  input  logic [STATUS_W-1:0] out_status,
  input  logic [OFFSET_W-1:0] out_offset,
  input  logic [BASE_W-1:0]   out_scope_base,
  output int                  fail_count,
  output int                  pending
);

  localparam logic [NAME_W-1:0] KEY_MASK = {NAME_W{1'b1}} >> (NAME_W - KEY_BITS);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] offset;
    logic [BASE_W-1:0]   base;
  } sym_result_t;

  // Shadow copy of the symbol table.
  logic [NAME_W-1:0] sym_keys [TOTAL_ENTRIES];
  int                scope_mark [MAX_SCOPES];
  int                live_cnt;
  int                open_scopes;

  sym_result_t       awaited_results [$];
  int                err_cnt = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Newest live entry holding the key, or -1.
  function automatic int find_live(input logic [NAME_W-1:0] key);
    for (int i = live_cnt - 1; i >= 0; i--) begin
      if (sym_keys[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic sym_result_t apply_symbol_op(input logic [OP_W-1:0] op,
                                                  input logic [NAME_W-1:0] raw_key);
    sym_result_t       r;
    logic [NAME_W-1:0] key;
    logic [31:0]       wide;
    int                hit;
    int                held;
    bit                placed;
    r      = '0;
    r.status = ST_OK;
    key    = raw_key & KEY_MASK;
    case (op)
      OP_ENTER: begin
        if (open_scopes >= MAX_SCOPES) begin
          r.status = ST_STACK_FULL;
        end else begin
          scope_mark[open_scopes] = live_cnt;
          open_scopes++;
          wide   = BASE_BIAS + live_cnt;
          r.base = wide[BASE_W-1:0];
        end
      end
      OP_EXIT: begin
        if (open_scopes > 1) begin
          open_scopes--;
          live_cnt = scope_mark[open_scopes];
        end
      end
      OP_DECLARE: begin
        held = live_cnt - scope_mark[open_scopes - 1];
        hit  = find_live(key);
        if (hit >= 0) begin
          r.status = ST_DUPLICATE;
        end else if (held >= VARS_PER_SCOPE) begin
          r.status = ST_SCOPE_FULL;
        end else if (live_cnt >= TOTAL_ENTRIES) begin
          r.status = ST_STACK_FULL;
        end else begin
          sym_keys[live_cnt] = key;
          live_cnt++;
          wide     = held;
          r.offset = wide[OFFSET_W-1:0];
        end
      end
      default: begin
        hit = find_live(key);
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else begin
          // The holding scope is the innermost one that starts at or below the hit.
          placed = 1'b0;
          wide   = hit;
          for (int s = open_scopes - 1; s >= 0; s--) begin
            if (!placed && scope_mark[s] <= hit) begin
              wide   = hit - scope_mark[s];
              placed = 1'b1;
            end
          end
          r.offset = wide[OFFSET_W-1:0];
        end
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin : watch
    sym_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < TOTAL_ENTRIES; i++) sym_keys[i] = '0;
      for (int i = 0; i < MAX_SCOPES; i++) scope_mark[i] = 0;
      live_cnt    = 0;
      open_scopes = 1;
      awaited_results.delete();
    end else begin
      // A result shown in the same cycle as a new transfer belongs to the older item.
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          $error("result with nothing expected: status %0d offset %0d scope_base %0d",
                 out_status, out_offset, out_scope_base);
          err_cnt++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", want.status, out_status);
          check_field("offset", want.offset, out_offset);
          check_field("scope_base", want.base, out_scope_base);
        end
      end
      if (start && !busy) awaited_results.push_back(apply_symbol_op(in_op, in_name_key));
    end
    pending    <= awaited_results.size();
    fail_count <= err_cnt;
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import sst_pkg::*;

  localparam int POOL_SIZE  = 24;
  localparam int ITEM_GOAL  = 1200;
  localparam int RECENT_CAP = 256;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [OP_W-1:0]     in_op = OP_ENTER;
  logic [NAME_W-1:0]   in_name_key = '0;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [OFFSET_W-1:0] out_offset;
  logic [BASE_W-1:0]   out_scope_base;
  int                  fail_count;
  int                  pending;

  logic [NAME_W-1:0]   key_pool [POOL_SIZE];
  logic [NAME_W-1:0]   recent_keys [$];
  int                  items_sent = 0;
  bit                  gaps_on = 1'b1;

  scoped_symbol_table_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_name_key    (in_name_key),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_offset     (out_offset),
    .out_scope_base (out_scope_base)
  );

  sst_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_name_key    (in_name_key),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_offset     (out_offset),
    .out_scope_base (out_scope_base),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // Drives one item and returns at the edge that completes its transfer.
  task automatic send_op(input logic [OP_W-1:0] op, input logic [NAME_W-1:0] key);
    int gap;
    start       <= 1'b1;
    in_op       <= op;
    in_name_key <= key;
    do @(posedge clk); while (busy);
    items_sent++;
    gap = 0;
    if (gaps_on) begin
      case ($urandom_range(9))
        0, 1, 2: gap = $urandom_range(3, 1);
        3:       gap = $urandom_range(40, 8);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [NAME_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return key_pool[$urandom_range(POOL_SIZE - 1)];
    if (r < 75 && recent_keys.size() > 0)
      return recent_keys[$urandom_range(recent_keys.size() - 1)];
    return {$urandom, $urandom};
  endfunction

  task automatic declare_fresh();
    logic [NAME_W-1:0] k;
    k = {$urandom, $urandom};
    recent_keys.push_back(k);
    if (recent_keys.size() > RECENT_CAP) void'(recent_keys.pop_front());
    send_op(OP_DECLARE, k);
  endtask

  task automatic mixed_burst(input int n);
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 15)      send_op(OP_ENTER, {$urandom, $urandom});
      else if (r < 30) send_op(OP_EXIT, {$urandom, $urandom});
      else if (r < 45) declare_fresh();
      else if (r < 65) send_op(OP_DECLARE, pick_key());
      else             send_op(OP_LOOKUP, pick_key());
    end
  endtask

  initial begin
    int seg;
    int fills;
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = {(NAME_W/2){2'b10}};
    key_pool[3] = {(NAME_W/2){2'b01}};
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: empty table, global exit, duplicates, scope nesting.
    send_op(OP_LOOKUP, key_pool[0]);
    send_op(OP_EXIT, key_pool[1]);
    send_op(OP_DECLARE, key_pool[1]);
    send_op(OP_DECLARE, key_pool[0]);
    send_op(OP_DECLARE, key_pool[1]);
    send_op(OP_LOOKUP, key_pool[1]);
    send_op(OP_ENTER, key_pool[3]);
    send_op(OP_DECLARE, key_pool[2]);
    send_op(OP_LOOKUP, key_pool[0]);
    send_op(OP_DECLARE, key_pool[0]);
    send_op(OP_LOOKUP, key_pool[3]);
    send_op(OP_LOOKUP, key_pool[2]);
    send_op(OP_ENTER, key_pool[0]);
    send_op(OP_DECLARE, key_pool[3]);
    send_op(OP_LOOKUP, key_pool[1]);
    send_op(OP_EXIT, key_pool[2]);
    send_op(OP_LOOKUP, key_pool[3]);
    send_op(OP_EXIT, key_pool[0]);
    send_op(OP_LOOKUP, key_pool[2]);
    send_op(OP_DECLARE, key_pool[3]);

    seg   = 0;
    fills = 0;
    while (items_sent < ITEM_GOAL) begin
      gaps_on = ($urandom_range(3) != 0);
      case (seg % 6)
        1: begin
          // Nest past the scope limit, then unwind past the global scope.
          repeat (MAX_SCOPES + 1) begin
            send_op(OP_ENTER, {$urandom, $urandom});
            if ($urandom_range(1)) declare_fresh();
          end
          repeat (6) send_op(OP_LOOKUP, pick_key());
          repeat (MAX_SCOPES + 1) send_op(OP_EXIT, {$urandom, $urandom});
        end
        3: begin
          if (fills < 2) begin
            // Fill whole scopes until the store runs out of entries.
            fills++;
            repeat (MAX_SCOPES) send_op(OP_EXIT, {$urandom, $urandom});
            repeat (TOTAL_ENTRIES / VARS_PER_SCOPE) begin
              repeat (VARS_PER_SCOPE + 2) declare_fresh();
              send_op(OP_ENTER, {$urandom, $urandom});
            end
            repeat (3) declare_fresh();
            repeat (12) send_op(OP_LOOKUP, pick_key());
            send_op(OP_DECLARE, key_pool[$urandom_range(POOL_SIZE - 1)]);
            send_op(OP_ENTER, {$urandom, $urandom});
          end else begin
            mixed_burst($urandom_range(80, 40));
          end
        end
        default: mixed_burst($urandom_range(80, 40));
      endcase
      seg++;
    end

    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
